// ===== hdl/mqts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqts_pkg
// Shared constants, codes and controller/datapath interface types for the
// two-stack max queue.
// ----------------------------------------------------------------------------
package mqts_pkg;

  localparam int DEPTH  = 1024;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_MAX   = 2'd2,
    OP_EMPTY = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_XFER_RD,
    ST_XFER_WR,
    ST_POP,
    ST_LOAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic set_err;
    logic take_max;
    logic push;
    logic xfer_rd;
    logic xfer_wr;
    logic pop;
    logic load;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    mode_t            mode;
    logic             empty;
    logic             full;
    logic             in_zero;
    logic             out_zero;
    logic             out_one;
    logic             out_free;
    logic [CNT_W-1:0] in_cnt;
    logic [CNT_W-1:0] out_cnt;
  } stat_t;

endpackage

// ===== hdl/max_queue_two_stacks.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_queue_two_stacks
// FIFO of signed 32-bit words that reports its maximum, built from two stacks
// with running maxima in one shared 1024-entry store.
//
// Command channel (cmd_valid/cmd_ready) takes mode and value; response channel
// (rsp_valid/rsp_ready) returns result_value, is_empty and error, one word per
// command, in order. mode 0 enqueues, 1 dequeues, 2 reads the maximum, 3 only
// reports is_empty. Dequeue or maximum on an empty queue and enqueue on a full
// one set error, return zero and leave the contents unchanged.
// Sequence: enqueue, maximum, query and error commands go from accept through an
// execute step to a done step that registers the response; a dequeue adds a
// pop step and a reload step of the outbound top (no reload when it pops the
// last outbound word), and when the outbound stack is empty the inbound stack
// is first drained onto it, one store read and one store write per word. A new
// command is taken only once the response is registered; each word is moved
// at most once.
// Reset empties both stacks; store contents are not cleared. A stalled
// receiver holds the response register; one further command is processed and
// waits in its done step until the response register frees.
// ----------------------------------------------------------------------------
module max_queue_two_stacks
  import mqts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] value,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     is_empty,
  output logic                     error
);

  ctrl_t ctl;
  stat_t st;

  mqts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .st        (st),
    .ctl       (ctl)
  );

  mqts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .value        (value),
    .ctl          (ctl),
    .st           (st),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .result_value (result_value),
    .is_empty     (is_empty),
    .error        (error)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command accepted while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && error) |-> (result_value == '0))
    else $error("error response with nonzero value");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, st.in_cnt} + {1'b0, st.out_cnt}) <= (CNT_W + 1)'(DEPTH))
    else $error("stack counts exceed capacity");

  a_push_on_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !st.full)
    else $error("push on full store");

endmodule

// ===== hdl/mqts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqts_ctrl
// Sequencer for the max queue: decodes the captured operation, runs the
// stack-to-stack transfer and the pop/reload steps, and hands off the result.
// ----------------------------------------------------------------------------
module mqts_ctrl
  import mqts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_ready,
  input  stat_t st,
  output ctrl_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        if (st.mode == OP_DEQ && !st.empty) begin
          state_next = st.out_zero ? ST_XFER_RD : ST_POP;
        end
      end
      ST_XFER_RD: state_next = ST_XFER_WR;
      ST_XFER_WR: state_next = st.in_zero ? ST_POP : ST_XFER_RD;
      ST_POP:     state_next = st.out_one ? ST_DONE : ST_LOAD;
      ST_LOAD:    state_next = ST_DONE;
      ST_DONE: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    cmd_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready   = 1'b1;
        ctl.capture = cmd_valid;
      end
      ST_EXEC: begin
        ctl.clear = 1'b1;
        case (st.mode)
          OP_ENQ: begin
            ctl.set_err = st.full;
            ctl.push    = !st.full;
          end
          OP_DEQ:  ctl.set_err = st.empty;
          OP_MAX: begin
            ctl.set_err  = st.empty;
            ctl.take_max = !st.empty;
          end
          default: ctl.set_err = 1'b0;
        endcase
      end
      ST_XFER_RD: ctl.xfer_rd = 1'b1;
      ST_XFER_WR: ctl.xfer_wr = 1'b1;
      ST_POP:     ctl.pop     = 1'b1;
      ST_LOAD:    ctl.load    = 1'b1;
      ST_DONE:    ctl.emit    = st.out_free;
      default:    ctl         = '0;
    endcase
  end

endmodule

// ===== hdl/mqts_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqts_dp
// Datapath for the max queue: shared stack store with running maxima,
// stack counters, cached stack tops and the result register.
// ----------------------------------------------------------------------------
module mqts_dp
  import mqts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] value,
  input  ctrl_t                    ctl,
  output stat_t                    st,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     is_empty,
  output logic                     error
);

  localparam logic [CNT_W:0]    FULL_CNT = (CNT_W + 1)'(DEPTH);
  localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] NXT_BASE = ADDR_W'(DEPTH + 1);

  logic [2*DATA_W-1:0] mem [DEPTH];
  logic [2*DATA_W-1:0] rdata;

  mode_t                    mode_r;
  logic signed [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]         in_cnt;
  logic [CNT_W-1:0]         out_cnt;
  logic signed [DATA_W-1:0] in_max;
  logic signed [DATA_W-1:0] out_top_val;
  logic signed [DATA_W-1:0] out_top_max;
  logic signed [DATA_W-1:0] res;
  logic                     err;

  logic signed [DATA_W-1:0] rd_val;
  logic signed [DATA_W-1:0] rd_max;
  logic signed [DATA_W-1:0] push_max;
  logic signed [DATA_W-1:0] xfer_max;
  logic signed [DATA_W-1:0] q_max;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [2*DATA_W-1:0]      wr_data;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic [CNT_W:0]           total;

  assign rd_val = rdata[DATA_W-1:0];
  assign rd_max = rdata[2*DATA_W-1:DATA_W];
  assign total  = {1'b0, in_cnt} + {1'b0, out_cnt};

  always_comb begin
    st.mode     = mode_r;
    st.in_zero  = (in_cnt == '0);
    st.out_zero = (out_cnt == '0);
    st.empty    = st.in_zero && st.out_zero;
    st.full     = (total >= FULL_CNT);
    st.out_one  = (out_cnt == CNT_W'(1));
    st.out_free = !rsp_valid || rsp_ready;
    st.in_cnt   = in_cnt;
    st.out_cnt  = out_cnt;
  end

  // running maxima for push, transfer and query
  always_comb begin
    push_max = (!st.in_zero && in_max > value_r) ? in_max : value_r;
    xfer_max = (!st.out_zero && out_top_max > rd_val) ? out_top_max : rd_val;
    if (st.in_zero) begin
      q_max = out_top_max;
    end else if (st.out_zero) begin
      q_max = in_max;
    end else begin
      q_max = (in_max > out_top_max) ? in_max : out_top_max;
    end
  end

  always_comb begin
    wr_en   = ctl.push || ctl.xfer_wr;
    wr_addr = ctl.push ? in_cnt[ADDR_W-1:0] : TOP_ADDR - out_cnt[ADDR_W-1:0];
    wr_data = ctl.push ? {push_max, value_r} : {xfer_max, rd_val};
    rd_en   = ctl.xfer_rd || ctl.pop;
    rd_addr = ctl.xfer_rd ? in_cnt[ADDR_W-1:0] - ADDR_W'(1)
                          : NXT_BASE - out_cnt[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt    <= '0;
      out_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.push) begin
        in_cnt <= in_cnt + CNT_W'(1);
      end else if (ctl.xfer_rd) begin
        in_cnt <= in_cnt - CNT_W'(1);
      end
      if (ctl.xfer_wr) begin
        out_cnt <= out_cnt + CNT_W'(1);
      end else if (ctl.pop) begin
        out_cnt <= out_cnt - CNT_W'(1);
      end
      if (ctl.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      mode_r  <= mode_t'(mode);
      value_r <= value;
    end
    if (ctl.push) in_max <= push_max;
    if (ctl.xfer_wr) begin
      out_top_val <= rd_val;
      out_top_max <= xfer_max;
    end else if (ctl.load) begin
      out_top_val <= rd_val;
      out_top_max <= rd_max;
    end
    if (ctl.clear) begin
      res <= ctl.take_max ? q_max : '0;
      err <= ctl.set_err;
    end else if (ctl.pop) begin
      res <= out_top_val;
    end
    if (ctl.emit) begin
      result_value <= res;
      error        <= err;
      is_empty     <= st.empty;
    end
  end

endmodule

// ===== verif/max_queue_two_stacks_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_queue_two_stacks_tb
// Self-checking bench for the two-stack max queue. A directed opening covers
// the empty-queue errors, extreme words, tied maxima and the stack transfer.
// Random traffic then mixes all four commands, fills the queue to capacity
// with enqueues rejected at full, and drains it down to half full. A shadow
// two-stack model predicts each response, which is checked field by field,
// in order, under bursty command traffic and patterned response stalls.
// ----------------------------------------------------------------------------
module max_queue_two_stacks_tb;
  import mqts_pkg::*;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    mode_t op;
    word_t data;
  } cmd_t;

  typedef struct packed {
    word_t result;
    logic  is_empty;
    logic  error;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  logic [1:0]  mode = OP_EMPTY;
  word_t       value = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  word_t       result_value;
  logic        is_empty;
  logic        error;

  max_queue_two_stacks dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .mode         (mode),
    .value        (value),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .result_value (result_value),
    .is_empty     (is_empty),
    .error        (error)
  );

  // shadow queue: inbound stack grows up from 0, outbound down from DEPTH-1
  word_t slot_value [DEPTH];
  word_t slot_max   [DEPTH];
  int    in_cnt = 0;
  int    out_cnt = 0;

  cmd_t  pending_cmds [$];
  resp_t expected_rsp [$];
  int    fill_level = 0;
  bit    cmd_fire = 1'b0;
  int    mismatches = 0;
  int    op_count [4] = '{0, 0, 0, 0};
  int    error_rsps = 0;
  int    peak_fill = 0;

  cmd_t  next_cmd;
  int    burst_left = 1;
  int    gap_left = 0;
  int    stall_cyc = 0;
  int    stall_style = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic resp_t apply_command(mode_t op, word_t din);
    resp_t r;
    word_t v;
    word_t m;
    r = '0;
    case (op)
      OP_ENQ: begin
        if (in_cnt + out_cnt >= DEPTH) begin
          r.error = 1'b1;
        end else begin
          m = din;
          if (in_cnt > 0 && slot_max[in_cnt-1] > din) m = slot_max[in_cnt-1];
          slot_value[in_cnt] = din;
          slot_max[in_cnt] = m;
          in_cnt++;
        end
      end
      OP_DEQ: begin
        if (in_cnt == 0 && out_cnt == 0) begin
          r.error = 1'b1;
        end else begin
          // refill outbound stack, reversing order
          if (out_cnt == 0) begin
            while (in_cnt > 0) begin
              in_cnt--;
              v = slot_value[in_cnt];
              m = v;
              if (out_cnt > 0 && slot_max[DEPTH-out_cnt] > v) m = slot_max[DEPTH-out_cnt];
              out_cnt++;
              slot_value[DEPTH-out_cnt] = v;
              slot_max[DEPTH-out_cnt] = m;
            end
          end
          r.result = slot_value[DEPTH-out_cnt];
          out_cnt--;
        end
      end
      OP_MAX: begin
        if (in_cnt == 0 && out_cnt == 0) begin
          r.error = 1'b1;
        end else if (in_cnt == 0) begin
          r.result = slot_max[DEPTH-out_cnt];
        end else if (out_cnt == 0) begin
          r.result = slot_max[in_cnt-1];
        end else begin
          r.result = (slot_max[in_cnt-1] > slot_max[DEPTH-out_cnt]) ?
                     slot_max[in_cnt-1] : slot_max[DEPTH-out_cnt];
        end
      end
      default: ;
    endcase
    r.is_empty = (in_cnt == 0 && out_cnt == 0);
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return word_t'($urandom_range(0, 15) - 8);
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic queue_command(mode_t op, word_t data);
    pending_cmds.push_back('{op: op, data: data});
    if (op == OP_ENQ && fill_level < DEPTH) fill_level++;
    else if (op == OP_DEQ && fill_level > 0) fill_level--;
  endtask

  // command driver
  always @(negedge clk) begin
    if (!rst && (!cmd_valid || cmd_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        mode <= next_cmd.op;
        value <= next_cmd.data;
        cmd_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // response stall pattern
  always @(negedge clk) begin
    if (!rst) begin
      stall_cyc++;
      if (stall_cyc == 97) begin
        stall_cyc = 0;
        stall_style = $urandom_range(0, 3);
      end
      case (stall_style)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= 1'($urandom_range(0, 1));
        2: rsp_ready <= (stall_cyc % 4 == 0);
        default: rsp_ready <= (stall_cyc % 40 >= 24);
      endcase
    end
  end

  // predict on accepted command, check accepted response word
  always @(posedge clk) begin
    resp_t exp_rsp;
    cmd_fire = !rst && cmd_valid && cmd_ready;
    if (cmd_fire) begin
      expected_rsp.push_back(apply_command(mode_t'(mode), value));
      op_count[mode]++;
      if (in_cnt + out_cnt > peak_fill) peak_fill = in_cnt + out_cnt;
    end
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response word: result %0d empty %0b error %0b",
                   result_value, is_empty, error);
      end else begin
        exp_rsp = expected_rsp.pop_front();
        if (exp_rsp.error) error_rsps++;
        if (result_value !== exp_rsp.result || is_empty !== exp_rsp.is_empty ||
            error !== exp_rsp.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected result %0d empty %0b error %0b, got %0d %0b %0b",
                     exp_rsp.result, exp_rsp.is_empty, exp_rsp.error,
                     result_value, is_empty, error);
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("max_queue_two_stacks regression: fail");
    $finish;
  end

  initial begin
    int    pick;
    mode_t op;

    // empty queue errors, extreme words, tied maxima, transfer
    queue_command(OP_EMPTY, rand_word());
    queue_command(OP_DEQ, rand_word());
    queue_command(OP_MAX, rand_word());
    queue_command(OP_ENQ, 32'sh8000_0000);
    queue_command(OP_MAX, rand_word());
    queue_command(OP_ENQ, 32'sh7fff_ffff);
    queue_command(OP_ENQ, -32'sd1);
    queue_command(OP_MAX, rand_word());
    queue_command(OP_DEQ, rand_word());
    queue_command(OP_ENQ, 32'sh7fff_ffff);
    queue_command(OP_MAX, rand_word());
    queue_command(OP_EMPTY, rand_word());
    queue_command(OP_ENQ, 32'sd0);
    queue_command(OP_DEQ, rand_word());
    queue_command(OP_DEQ, rand_word());
    queue_command(OP_MAX, rand_word());
    queue_command(OP_DEQ, rand_word());
    queue_command(OP_DEQ, rand_word());
    queue_command(OP_EMPTY, rand_word());
    queue_command(OP_DEQ, rand_word());
    queue_command(OP_MAX, rand_word());

    // balanced mix
    for (int i = 0; i < 150; i++) begin
      pick = $urandom_range(0, 9);
      op = (pick < 4) ? OP_ENQ : (pick < 7) ? OP_DEQ : (pick < 9) ? OP_MAX : OP_EMPTY;
      queue_command(op, rand_word());
    end

    // fill to capacity, then push against full
    while (fill_level < DEPTH) begin
      pick = $urandom_range(0, 99);
      op = (pick < 96) ? OP_ENQ : (pick < 98) ? OP_MAX : (pick < 99) ? OP_DEQ : OP_EMPTY;
      queue_command(op, rand_word());
    end
    repeat (4) queue_command(OP_ENQ, rand_word());
    queue_command(OP_MAX, rand_word());
    queue_command(OP_EMPTY, rand_word());
    queue_command(OP_ENQ, rand_word());

    // drain down to half full
    while (fill_level > DEPTH / 2) begin
      pick = $urandom_range(0, 99);
      op = (pick < 92) ? OP_DEQ : (pick < 96) ? OP_ENQ : (pick < 98) ? OP_MAX : OP_EMPTY;
      queue_command(op, rand_word());
    end
    queue_command(OP_DEQ, rand_word());
    queue_command(OP_MAX, rand_word());
    queue_command(OP_EMPTY, rand_word());

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || cmd_valid || expected_rsp.size() > 0)
      @(negedge clk);
    repeat (40) @(posedge clk);

    $display("%0d commands run: enq %0d, deq %0d, max %0d, query %0d",
             op_count[OP_ENQ] + op_count[OP_DEQ] + op_count[OP_MAX] + op_count[OP_EMPTY],
             op_count[OP_ENQ], op_count[OP_DEQ], op_count[OP_MAX], op_count[OP_EMPTY]);
    $display("%0d error responses, peak occupancy %0d of %0d, %0d mismatches",
             error_rsps, peak_fill, DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("max_queue_two_stacks regression: pass");
    end else begin
      $display("max_queue_two_stacks regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mqts_pkg.sv
hdl/mqts_ctrl.sv
hdl/mqts_dp.sv
hdl/max_queue_two_stacks.sv
verif/max_queue_two_stacks_tb.sv
